// ===== rtl/calendar_time_field_editor_assert.svh =====
// ---------------------------------------------------------------------------
// Calendar time field editor assertion macros
// Shared wrappers for the concurrent checks of the editor.
// ---------------------------------------------------------------------------
`ifndef CALENDAR_TIME_FIELD_EDITOR_ASSERT_SVH
`define CALENDAR_TIME_FIELD_EDITOR_ASSERT_SVH

// The condition holds at every clock edge outside reset.
`define CTFE_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("calendar editor check failed");

// The consequent holds at the clock edge after the antecedent.
`define CTFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("calendar editor check failed");

`endif

// ===== rtl/ctfe_pkg.sv =====
// ---------------------------------------------------------------------------
// Calendar time field editor package
// Payload types, command and field codes, bounds and the month length table.
// ---------------------------------------------------------------------------
package ctfe_pkg;

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_NEXT = 2'd1;
    localparam logic [1:0] CMD_INC  = 2'd2;
    localparam logic [1:0] CMD_DEC  = 2'd3;

    localparam logic [2:0] FLD_YEAR    = 3'd0;
    localparam logic [2:0] FLD_MONTH   = 3'd1;
    localparam logic [2:0] FLD_DAY     = 3'd2;
    localparam logic [2:0] FLD_HOUR    = 3'd3;
    localparam logic [2:0] FLD_MINUTE  = 3'd4;
    localparam logic [2:0] FLD_SECOND  = 3'd5;
    localparam logic [2:0] FLD_WEEKDAY = 3'd6;

    localparam logic [6:0] YEAR_MAX    = 7'd99;
    localparam logic [3:0] MONTH_MAX   = 4'd12;
    localparam logic [4:0] HOUR_MAX    = 5'd23;
    localparam logic [5:0] MINUTE_MAX  = 6'd59;
    localparam logic [5:0] SECOND_MAX  = 6'd59;
    localparam logic [2:0] WEEKDAY_MAX = 3'd7;

    typedef struct packed {
        logic [1:0] command;
        logic [6:0] load_year;
        logic [3:0] load_month;
        logic [4:0] load_day;
        logic [4:0] load_hour;
        logic [5:0] load_minute;
        logic [5:0] load_second;
        logic [2:0] load_weekday;
    } ctfe_in_t;

    typedef struct packed {
        logic [6:0] year_out;
        logic [3:0] month_out;
        logic [4:0] day_out;
        logic [4:0] hour_out;
        logic [5:0] minute_out;
        logic [5:0] second_out;
        logic [2:0] weekday_out;
        logic [2:0] selected_field;
    } ctfe_out_t;

    typedef struct packed {
        logic [6:0] year;
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [2:0] weekday;
        logic [2:0] select;
    } ctfe_cal_t;

    localparam ctfe_cal_t CAL_RESET = '{
        year:    7'd0,
        month:   4'd1,
        day:     5'd1,
        hour:    5'd0,
        minute:  6'd0,
        second:  6'd0,
        weekday: 3'd1,
        select:  FLD_YEAR
    };

    // Months that are not 30 or 31 days long, month zero included, get
    // the length of February.
    function automatic logic [4:0] month_length(input logic [3:0] month,
                                                input logic [6:0] year);
        logic [4:0] len;
        unique case (month) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12:
                len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:
                len = 5'd30;
            default:
                len = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
        endcase
        return len;
    endfunction

endpackage

// ===== rtl/ctfe_update.sv =====
// ---------------------------------------------------------------------------
// Calendar time field editor update logic
// Computes the next calendar state from the current state and one command.
// ---------------------------------------------------------------------------
module ctfe_update
    import ctfe_pkg::*;
(
    input  ctfe_cal_t cur,
    input  ctfe_in_t  item,
    output ctfe_cal_t nxt
);

    logic [2:0] idx;
    logic [6:0] fv;
    logic [6:0] fhi;
    logic [6:0] flo;
    logic [6:0] fstep;
    logic [4:0] mlen_cur;
    logic [4:0] mlen_new;
    logic [6:0] ld_year;
    logic [3:0] ld_month;
    logic [4:0] ld_mlen;

    assign idx      = (cur.select <= FLD_WEEKDAY) ? cur.select : FLD_YEAR;
    assign mlen_cur = month_length(cur.month, cur.year);
    assign ld_year  = (item.load_year > YEAR_MAX) ? YEAR_MAX : item.load_year;
    assign ld_month = (item.load_month > MONTH_MAX) ? MONTH_MAX : item.load_month;
    assign ld_mlen  = month_length(ld_month, ld_year);
    assign mlen_new = month_length(fstep[3:0], cur.year);

    always_comb
    begin
        fv  = 7'd0;
        fhi = 7'd0;
        flo = 7'd0;
        unique case (idx)
            FLD_YEAR:
            begin
                fv  = cur.year;
                fhi = YEAR_MAX;
            end
            FLD_MONTH:
            begin
                fv  = {3'd0, cur.month};
                fhi = {3'd0, MONTH_MAX};
                flo = 7'd1;
            end
            FLD_DAY:
            begin
                fv  = {2'd0, cur.day};
                fhi = {2'd0, mlen_cur};
                flo = 7'd1;
            end
            FLD_HOUR:
            begin
                fv  = {2'd0, cur.hour};
                fhi = {2'd0, HOUR_MAX};
            end
            FLD_MINUTE:
            begin
                fv  = {1'd0, cur.minute};
                fhi = {1'd0, MINUTE_MAX};
            end
            FLD_SECOND:
            begin
                fv  = {1'd0, cur.second};
                fhi = {1'd0, SECOND_MAX};
            end
            default:
            begin
                fv  = {4'd0, cur.weekday};
                fhi = {4'd0, WEEKDAY_MAX};
                flo = 7'd1;
            end
        endcase

        if (item.command == CMD_INC)
        begin
            fstep = (fv >= fhi) ? flo : fv + 7'd1;
        end
        else
        begin
            fstep = (fv <= flo) ? fhi : fv - 7'd1;
        end
    end

    always_comb
    begin
        nxt = cur;
        unique case (item.command)
            CMD_LOAD:
            begin
                nxt.year    = ld_year;
                nxt.month   = ld_month;
                nxt.day     = (item.load_day > ld_mlen) ? ld_mlen : item.load_day;
                nxt.hour    = (item.load_hour > HOUR_MAX) ? HOUR_MAX : item.load_hour;
                nxt.minute  = (item.load_minute > MINUTE_MAX) ? MINUTE_MAX
                                                              : item.load_minute;
                nxt.second  = (item.load_second > SECOND_MAX) ? SECOND_MAX
                                                              : item.load_second;
                nxt.weekday = item.load_weekday;
            end
            CMD_NEXT:
            begin
                nxt.select = (cur.select >= FLD_WEEKDAY) ? FLD_YEAR : cur.select + 3'd1;
            end
            default:
            begin
                unique case (idx)
                    FLD_YEAR:
                    begin
                        nxt.year = fstep;
                    end
                    FLD_MONTH:
                    begin
                        nxt.month = fstep[3:0];
                        if (cur.day > mlen_new)
                        begin
                            nxt.day = mlen_new;
                        end
                    end
                    FLD_DAY:
                    begin
                        nxt.day = fstep[4:0];
                    end
                    FLD_HOUR:
                    begin
                        nxt.hour = fstep[4:0];
                    end
                    FLD_MINUTE:
                    begin
                        nxt.minute = fstep[5:0];
                    end
                    FLD_SECOND:
                    begin
                        nxt.second = fstep[5:0];
                    end
                    default:
                    begin
                        nxt.weekday = fstep[2:0];
                    end
                endcase
            end
        endcase
    end

endmodule

// ===== rtl/calendar_time_field_editor.sv =====
// ---------------------------------------------------------------------------
// Calendar time field editor
// Holds a calendar time and a selected field, and applies one command per
// input transfer: load all fields, select the next field, or step the
// selected field up or down with wraparound.
//
// Channels: the input channel (in_valid, in_ready, in_data) carries one
// command with its load values; the output channel (out_valid, out_ready,
// out_data) returns one result per command, showing every field and the
// selected field after the command has taken effect.
// Path: a command accepted at the input is registered in the input register
// and applied when the result register can load; its result then shows there.
// Throughput: one command per cycle while out_ready is held high, set by the
// single update stage between the input register and the result register.
// Reset: the time returns to year 0, month 1, day 1, 00:00:00, weekday 1,
// with the year selected; both stages are emptied.
// Stall: while the receiver holds out_ready low, the result waits in the
// result register, one more command waits in the input register, and
// in_ready drops until the result is taken.
// ---------------------------------------------------------------------------
`include "calendar_time_field_editor_assert.svh"

module calendar_time_field_editor
    import ctfe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  ctfe_in_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output ctfe_out_t out_data
);

    logic      in_valid_reg;
    ctfe_in_t  in_data_reg;
    logic      out_valid_reg;
    ctfe_out_t out_data_reg;
    ctfe_cal_t cal_reg;
    ctfe_cal_t cal_next;
    logic      out_load;
    logic      advance;

    ctfe_update u_update (
        .cur  (cal_reg),
        .item (in_data_reg),
        .nxt  (cal_next)
    );

    assign out_load  = !out_valid_reg || out_ready;
    assign advance   = in_valid_reg && out_load;
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cal_reg       <= CAL_RESET;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                cal_reg       <= cal_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_data_reg <= in_data;
        end
        if (advance)
        begin
            out_data_reg <= '{
                year_out:       cal_next.year,
                month_out:      cal_next.month,
                day_out:        cal_next.day,
                hour_out:       cal_next.hour,
                minute_out:     cal_next.minute,
                second_out:     cal_next.second,
                weekday_out:    cal_next.weekday,
                selected_field: cal_next.select
            };
        end
    end

    `CTFE_ASSERT_ALWAYS(a_select_range, clk, rst_n, cal_reg.select <= FLD_WEEKDAY)
    `CTFE_ASSERT_NEXT(a_advance_fills_output, clk, rst_n, advance, out_valid_reg)
    `CTFE_ASSERT_NEXT(a_result_matches_state, clk, rst_n, advance,
        out_data_reg.day_out == cal_reg.day && out_data_reg.selected_field == cal_reg.select)
    `CTFE_ASSERT_NEXT(a_stall_holds_input, clk, rst_n,
        in_valid_reg && out_valid_reg && !out_ready, in_valid_reg)

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Calendar time field editor testbench
// Sends load, next-field, increment and decrement commands through the input
// channel with random gaps, and takes every result with random back-pressure.
// The testbench keeps its own copy of the calendar. Each returned readout
// is checked field by field against the calendar state that it predicted
// for the command.
// ---------------------------------------------------------------------------
module tb_top;
    import ctfe_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 1350;
    localparam int unsigned CYCLE_LIMIT  = 300000;
    localparam int unsigned DRAIN_CYCLES = 10;
    localparam int unsigned REPORT_LIMIT = 10;

    localparam ctfe_cal_t CAL_AT_RESET = '{
        year:    7'd0,
        month:   4'd1,
        day:     5'd1,
        hour:    5'd0,
        minute:  6'd0,
        second:  6'd0,
        weekday: 3'd1,
        select:  FLD_YEAR
    };

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    ctfe_in_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    ctfe_out_t out_data;

    ctfe_in_t    cmd_backlog[$];
    ctfe_out_t   pending_readouts[$];
    ctfe_cal_t   cal_now = CAL_AT_RESET;
    ctfe_out_t   want;
    logic        in_xfer = 1'b0;

    int unsigned total_items  = 0;
    int unsigned results_seen = 0;
    int unsigned error_count  = 0;
    int unsigned cycle_count  = 0;
    int unsigned send_gap     = 0;
    int unsigned send_calm    = 0;
    int unsigned hold_left    = 0;
    int unsigned ready_calm   = 0;
    int unsigned long_holds   = 0;

    calendar_time_field_editor i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        forever
        begin
            #1 clk = ~clk;
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    function automatic logic [4:0] days_in(input logic [3:0] month, input logic [6:0] year);
        case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12:
                return 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:
                return 5'd30;
            default:
                return ((year % 4) == 0) ? 5'd29 : 5'd28;
        endcase
    endfunction

    function automatic ctfe_cal_t apply_command(input ctfe_cal_t c, input ctfe_in_t it);
        logic [2:0] fld;
        logic [6:0] v;
        logic [6:0] lo;
        logic [6:0] hi;
        case (it.command)
            CMD_LOAD:
            begin
                c.year    = (it.load_year > YEAR_MAX) ? YEAR_MAX : it.load_year;
                c.month   = (it.load_month > MONTH_MAX) ? MONTH_MAX : it.load_month;
                hi        = 7'(days_in(c.month, c.year));
                c.day     = (7'(it.load_day) > hi) ? hi[4:0] : it.load_day;
                c.hour    = (it.load_hour > HOUR_MAX) ? HOUR_MAX : it.load_hour;
                c.minute  = (it.load_minute > MINUTE_MAX) ? MINUTE_MAX : it.load_minute;
                c.second  = (it.load_second > SECOND_MAX) ? SECOND_MAX : it.load_second;
                c.weekday = (it.load_weekday > WEEKDAY_MAX) ? WEEKDAY_MAX : it.load_weekday;
            end
            CMD_NEXT:
            begin
                c.select = (c.select >= FLD_WEEKDAY) ? FLD_YEAR : c.select + 3'd1;
            end
            default:
            begin
                fld = (c.select > FLD_WEEKDAY) ? FLD_YEAR : c.select;
                case (fld)
                    FLD_YEAR:
                    begin
                        v  = c.year;
                        hi = YEAR_MAX;
                    end
                    FLD_MONTH:
                    begin
                        v  = 7'(c.month);
                        hi = 7'(MONTH_MAX);
                    end
                    FLD_DAY:
                    begin
                        v  = 7'(c.day);
                        hi = 7'(days_in(c.month, c.year));
                    end
                    FLD_HOUR:
                    begin
                        v  = 7'(c.hour);
                        hi = 7'(HOUR_MAX);
                    end
                    FLD_MINUTE:
                    begin
                        v  = 7'(c.minute);
                        hi = 7'(MINUTE_MAX);
                    end
                    FLD_SECOND:
                    begin
                        v  = 7'(c.second);
                        hi = 7'(SECOND_MAX);
                    end
                    default:
                    begin
                        v  = 7'(c.weekday);
                        hi = 7'(WEEKDAY_MAX);
                    end
                endcase
                lo = (fld == FLD_MONTH || fld == FLD_DAY || fld == FLD_WEEKDAY) ? 7'd1 : 7'd0;
                if (it.command == CMD_INC)
                    v = (v >= hi) ? lo : v + 7'd1;
                else
                    v = (v <= lo) ? hi : v - 7'd1;
                case (fld)
                    FLD_YEAR:   c.year    = v;
                    FLD_MONTH:  c.month   = v[3:0];
                    FLD_DAY:    c.day     = v[4:0];
                    FLD_HOUR:   c.hour    = v[4:0];
                    FLD_MINUTE: c.minute  = v[5:0];
                    FLD_SECOND: c.second  = v[5:0];
                    default:    c.weekday = v[2:0];
                endcase
                if (fld == FLD_MONTH && c.day > days_in(c.month, c.year))
                    c.day = days_in(c.month, c.year);
            end
        endcase
        return c;
    endfunction

    task automatic push_step(input logic [1:0] op);
        logic [63:0] noise;
        ctfe_in_t    it;
        noise      = {$urandom, $urandom};
        it         = noise[$bits(ctfe_in_t)-1:0];
        it.command = op;
        if (op == CMD_LOAD && $urandom_range(0, 2) == 0)
            it.load_day = 5'($urandom_range(27, 31));
        cmd_backlog.push_back(it);
    endtask

    task automatic push_load(input logic [6:0] y, input logic [3:0] m, input logic [4:0] d,
                             input logic [4:0] h, input logic [5:0] mi, input logic [5:0] s,
                             input logic [2:0] wd);
        ctfe_in_t it;
        it.command      = CMD_LOAD;
        it.load_year    = y;
        it.load_month   = m;
        it.load_day     = d;
        it.load_hour    = h;
        it.load_minute  = mi;
        it.load_second  = s;
        it.load_weekday = wd;
        cmd_backlog.push_back(it);
    endtask

    function automatic int unsigned draw_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    initial
    begin
        int unsigned pick;
        int unsigned run;
        logic [1:0]  op;

        // Directed part: selection starts on the year.
        push_step(CMD_INC);
        push_load(7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 3'd0);
        push_load(7'd127, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63, 3'd7);
        push_step(CMD_INC);
        push_step(CMD_DEC);
        // Leap February clamps day 31 to 29; the year step then leaves it above the bound.
        push_load(7'd0, 4'd2, 5'd31, 5'd12, 6'd30, 6'd30, 3'd3);
        push_step(CMD_INC);
        push_step(CMD_NEXT);
        push_step(CMD_NEXT);
        push_step(CMD_INC);
        push_step(CMD_DEC);
        push_load(7'd4, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 3'd0);
        push_step(CMD_DEC);
        push_load(7'd5, 4'd0, 5'd31, 5'd0, 6'd0, 6'd0, 3'd0);
        push_step(CMD_INC);
        push_step(CMD_NEXT);
        push_step(CMD_DEC);
        push_step(CMD_INC);
        push_step(CMD_NEXT);
        push_step(CMD_DEC);
        push_step(CMD_NEXT);
        push_step(CMD_NEXT);
        push_step(CMD_INC);
        push_step(CMD_DEC);
        push_step(CMD_NEXT);
        push_step(CMD_NEXT);
        push_load(7'd1, 4'd3, 5'd31, 5'd1, 6'd1, 6'd1, 3'd1);
        push_step(CMD_DEC);
        push_load(7'd0, 4'd0, 5'd15, 5'd1, 6'd1, 6'd1, 3'd1);
        push_step(CMD_INC);

        total_items = cmd_backlog.size() + RANDOM_ITEMS;
        while (cmd_backlog.size() < total_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 18)
                push_step(CMD_LOAD);
            else if (pick < 40)
                push_step(CMD_NEXT);
            else
            begin
                op  = (pick < 70) ? CMD_INC : CMD_DEC;
                run = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 70)
                                                    : $urandom_range(1, 6);
                repeat (run)
                begin
                    if (cmd_backlog.size() < total_items)
                        push_step(op);
                end
            end
        end

        wait (results_seen >= total_items);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_readouts.size() == 0)
            $display("calendar_time_field_editor regression: pass");
        else
            $display("calendar_time_field_editor regression: fail");
        $finish;
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (in_valid && !in_xfer)
        begin
        end
        else if (send_gap > 0)
        begin
            send_gap = send_gap - 1;
            in_valid <= 1'b0;
        end
        else if (cmd_backlog.size() > 0)
        begin
            in_data  <= cmd_backlog.pop_front();
            in_valid <= 1'b1;
            if (send_calm > 0)
                send_calm = send_calm - 1;
            else if ($urandom_range(0, 49) == 0)
                send_calm = $urandom_range(20, 60);
            send_gap = (send_calm > 0) ? 0 : draw_gap();
        end
        else
        begin
            in_valid <= 1'b0;
        end
    end

    // A long hold-off twice in the run lets the block fill up and drop in_ready.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (long_holds < 2 && results_seen >= 300 + 600 * long_holds)
        begin
            long_holds = long_holds + 1;
            hold_left  = 60;
            out_ready <= 1'b0;
        end
        else if (ready_calm > 0)
        begin
            ready_calm = ready_calm - 1;
            out_ready <= 1'b1;
        end
        else
        begin
            if ($urandom_range(0, 49) == 0)
                ready_calm = $urandom_range(20, 60);
            hold_left = draw_gap();
            out_ready <= (hold_left == 0);
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_xfer <= 1'b0;
            cal_now = CAL_AT_RESET;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen = results_seen + 1;
                if (pending_readouts.size() == 0)
                begin
                    error_count = error_count + 1;
                    if (error_count <= REPORT_LIMIT)
                        $display("%0t: readout transfer with nothing expected", $realtime);
                end
                else
                begin
                    want = pending_readouts.pop_front();
                    if (out_data.year_out !== want.year_out
                            || out_data.month_out !== want.month_out
                            || out_data.day_out !== want.day_out
                            || out_data.hour_out !== want.hour_out
                            || out_data.minute_out !== want.minute_out
                            || out_data.second_out !== want.second_out
                            || out_data.weekday_out !== want.weekday_out
                            || out_data.selected_field !== want.selected_field)
                    begin
                        error_count = error_count + 1;
                        if (error_count <= REPORT_LIMIT)
                            $display("%0t: readout mismatch, expected %0d-%0d-%0d %0d:%0d:%0d",
                                     $realtime,
                                     want.year_out, want.month_out, want.day_out,
                                     want.hour_out, want.minute_out, want.second_out,
                                     " wd %0d sel %0d, got %0d-%0d-%0d %0d:%0d:%0d",
                                     want.weekday_out, want.selected_field,
                                     out_data.year_out, out_data.month_out,
                                     out_data.day_out, out_data.hour_out,
                                     out_data.minute_out, out_data.second_out,
                                     " wd %0d sel %0d",
                                     out_data.weekday_out, out_data.selected_field);
                    end
                end
            end
            in_xfer <= in_valid && in_ready;
            if (in_valid && in_ready)
            begin
                cal_now = apply_command(cal_now, in_data);
                want.year_out       = cal_now.year;
                want.month_out      = cal_now.month;
                want.day_out        = cal_now.day;
                want.hour_out       = cal_now.hour;
                want.minute_out     = cal_now.minute;
                want.second_out     = cal_now.second;
                want.weekday_out    = cal_now.weekday;
                want.selected_field = cal_now.select;
                pending_readouts.push_back(want);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("calendar_time_field_editor regression: fail");
            $finish;
        end
    end

endmodule
